FILE: rtl/core/gem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gem_pkg;

    localparam int DefMaxWidth  = 2048;
    localparam int DefMaxHeight = 4096;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 13;

    localparam logic [CfgIdxW-1:0] REG_OP_MODE      = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [1:0] OP_SOBEL   = 2'd0;
    localparam logic [1:0] OP_SCHARR  = 2'd1;
    localparam logic [1:0] OP_PREWITT = 2'd2;
    localparam logic [1:0] OP_ROBERTS = 2'd3;

    localparam logic [7:0] ALPHA_VAL = 8'd255;
    localparam logic [7:0] EDGE_MAX  = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic [7:0] alpha_out;
        logic       frame_last;
    } t_out_item;

    // gradient result for one channel: squared sum, saturation flag
    typedef struct packed {
        logic        sat;
        logic [15:0] sq;
    } t_grad;

    // one step of the restoring square root, carried from cell to cell
    typedef struct packed {
        logic [15:0] rad;
        logic [7:0]  root;
    } t_sqrt_st;

endpackage
`default_nettype wire

FILE: rtl/core/gem_grad.sv
`timescale 1ns / 1ps
`default_nettype none
// gradient of one channel over the 3x3 window, registered squared magnitude
module gem_grad
    import gem_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_p [9],
    output t_grad           o_grad
);
    logic signed [12:0] w_gx, w_gy;
    logic [11:0] w_ax, w_ay;
    logic signed [10:0] p0, p1, p2, p3, p4, p5, p6, p7, p8;
    t_grad r_grad;
    logic [24:0] w_s;

    always_comb begin
        p0 = 11'(i_p[0]); p1 = 11'(i_p[1]); p2 = 11'(i_p[2]);
        p3 = 11'(i_p[3]); p4 = 11'(i_p[4]); p5 = 11'(i_p[5]);
        p6 = 11'(i_p[6]); p7 = 11'(i_p[7]); p8 = 11'(i_p[8]);
        case (i_mode)
            OP_SOBEL: begin
                w_gx = 13'(p2 - p0) + 13'((p5 - p3) <<< 1) + 13'(p8 - p6);
                w_gy = 13'(p6 - p0) + 13'((p7 - p1) <<< 1) + 13'(p8 - p2);
            end
            OP_SCHARR: begin
                w_gx = 13'(p2 - p0) * 13'sd3 + 13'(p5 - p3) * 13'sd10
                     + 13'(p8 - p6) * 13'sd3;
                w_gy = 13'(p6 - p0) * 13'sd3 + 13'(p7 - p1) * 13'sd10
                     + 13'(p8 - p2) * 13'sd3;
            end
            OP_PREWITT: begin
                w_gx = 13'(p2 - p0) + 13'(p5 - p3) + 13'(p8 - p6);
                w_gy = 13'(p6 - p0) + 13'(p7 - p1) + 13'(p8 - p2);
            end
            OP_ROBERTS: begin
                w_gx = 13'(p1 - p3);
                w_gy = 13'(p0 - p4);
            end
            default: begin
                w_gx = '0;
                w_gy = '0;
            end
        endcase
        w_ax = w_gx[12] ? 12'(-w_gx) : w_gx[11:0];
        w_ay = w_gy[12] ? 12'(-w_gy) : w_gy[11:0];
        w_s = 25'(w_ax) * 25'(w_ax) + 25'(w_ay) * 25'(w_ay);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grad.sat <= (w_s[24:16] != '0);
            r_grad.sq  <= w_s[15:0];
        end
    end
    assign o_grad = r_grad;
endmodule
`default_nettype wire

FILE: rtl/core/gem_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one root bit of the restoring square root; a row of these forms the chain
module gem_sqrt_cell
    import gem_pkg::*;
#(
    parameter int BIT = 7
) (
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_sqrt_st i_st,
    output t_sqrt_st      o_st
);
    logic [7:0]  w_try;
    logic [15:0] w_sq;
    t_sqrt_st    r_st;

    always_comb begin
        w_try = i_st.root | (8'd1 << BIT);
        w_sq  = 16'(w_try) * 16'(w_try);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st.rad  <= i_st.rad;
            r_st.root <= (w_sq <= i_st.rad) ? w_try : i_st.root;
        end
    end
    assign o_st = r_st;
endmodule
`default_nettype wire

FILE: rtl/core/gradient_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | handshake            | payload
// cfg      | in  | i_cfg_we             | i_cfg_index, i_cfg_data
// pixel    | in  | i_valid / o_stall    | i_data (t_in_item)
// edge     | out | o_valid / i_stall    | o_data (t_out_item)
// one item per cycle sustained while the output is not stalled; a result passes, in order,
// through the line store read, gradient, eight square root cells and the output register
// the whole chain advances only when the output register can take data
// reset is synchronous active low; the line store needs no clearing
module gradient_edge_magnitude
    import gem_pkg::*;
#(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire t_in_item            i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output t_out_item                o_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int NW = $clog2(MAX_WIDTH + 2) + 1;

    logic [1:0]  r_mode;
    logic [11:0] r_width;
    logic [12:0] r_height;
    logic [CW:0] w_w;
    logic [RW:0] w_h;

    always_comb begin
        if (r_width == '0) w_w = (CW+1)'(1);
        else if (32'(r_width) > MAX_WIDTH) w_w = (CW+1)'(MAX_WIDTH);
        else w_w = (CW+1)'(r_width);
        if (r_height == '0) w_h = (RW+1)'(1);
        else if (32'(r_height) > MAX_HEIGHT) w_h = (RW+1)'(MAX_HEIGHT);
        else w_h = (RW+1)'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= OP_SOBEL;
            r_width  <= 12'd640;
            r_height <= 13'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OP_MODE:      r_mode   <= i_cfg_data[1:0];
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[11:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: output register free or being drained
    logic w_adv, w_acc;
    logic r_ovalid;
    t_out_item r_odata;
    assign w_adv   = !r_ovalid || !i_stall;
    assign o_stall = !w_adv;
    assign w_acc   = i_valid && w_adv;

    logic [CW-1:0] r_icol, r_ocol;
    logic [RW-1:0] r_irow, r_orow;
    logic [NW-1:0] r_wait;
    logic w_pix, w_emit, w_use;
    logic w_frame_start;

    assign w_pix = w_acc && !i_data.flush;
    assign w_frame_start = (r_icol == '0) && (r_irow == '0);
    always_comb begin
        w_emit = 1'b0;
        w_use  = 1'b0;
        if (w_pix) begin
            w_emit = (r_wait + 1'b1) > NW'(w_w + 1'b1);
            w_use  = 1'b1;
        end else if (w_acc) begin
            w_emit = (r_wait != '0) && w_frame_start;
        end
    end

    // line store: two banks, read at the incoming column, written at the registered column
    logic [23:0] r_ls0 [MAX_WIDTH];
    logic [23:0] r_ls1 [MAX_WIDTH];
    logic [23:0] r_above, r_above2, r_pix;
    logic        r_s1_pix, r_s1_emit, r_s1_use;
    logic [CW-1:0] r_s1_col;
    logic [23:0] w_above, w_above2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_above  <= r_ls0[r_icol];
            r_above2 <= r_ls1[r_icol];
            r_pix    <= {i_data.blue, i_data.green, i_data.red};
            r_s1_col <= r_icol;
        end
        if (r_s1_pix && w_adv) begin
            r_ls0[r_s1_col] <= r_pix;
            r_ls1[r_s1_col] <= w_above;
        end
    end

    // forward a write in flight at the same column (width 1 case)
    logic r_fwd_hit;
    logic [23:0] r_fwd0, r_fwd1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (w_adv) begin
            r_fwd_hit <= r_s1_pix && (r_s1_col == r_icol);
            r_fwd0    <= r_pix;
            r_fwd1    <= w_above;
        end
    end
    assign w_above  = r_fwd_hit ? r_fwd0 : r_above;
    assign w_above2 = r_fwd_hit ? r_fwd1 : r_above2;

    logic [23:0] r_win [9];
    logic [23:0] w_win [9];
    always_comb begin
        w_win = r_win;
        if (r_s1_pix) begin
            for (int r = 0; r < 3; r++) begin
                w_win[r*3]   = r_win[r*3+1];
                w_win[r*3+1] = r_win[r*3+2];
            end
            w_win[2] = w_above2;
            w_win[5] = w_above;
            w_win[8] = r_pix;
        end
    end

    // output position, computed at issue
    logic w_int, w_last;
    logic r_s1_int, r_s1_last;
    always_comb begin
        w_int = (r_ocol >= CW'(1)) && ((CW+1)'(r_ocol) + 1'b1 < w_w)
             && (r_orow >= RW'(1)) && ((RW+1)'(r_orow) + 1'b1 < w_h);
        w_last = ((CW+1)'(r_ocol) + 1'b1 >= w_w) && ((RW+1)'(r_orow) + 1'b1 >= w_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol <= '0; r_irow <= '0; r_ocol <= '0; r_orow <= '0;
            r_wait <= '0; r_s1_pix <= 1'b0; r_s1_emit <= 1'b0;
            r_s1_use <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (w_adv) begin
            r_s1_pix  <= w_pix;
            r_s1_emit <= w_emit;
            r_s1_use  <= w_use;
            r_s1_int  <= w_int;
            r_s1_last <= w_last;
            r_win     <= w_win;
            if (w_pix) begin
                if ((CW+1)'(r_icol) + 1'b1 >= w_w) begin
                    r_icol <= '0;
                    r_irow <= ((RW+1)'(r_irow) + 1'b1 >= w_h) ? '0 : r_irow + 1'b1;
                end else begin
                    r_icol <= r_icol + 1'b1;
                end
            end
            if (w_pix && !w_emit) r_wait <= r_wait + 1'b1;
            else if (!w_pix && w_emit) r_wait <= r_wait - 1'b1;
            if (w_emit) begin
                if ((CW+1)'(r_ocol) + 1'b1 >= w_w) begin
                    r_ocol <= '0;
                    r_orow <= ((RW+1)'(r_orow) + 1'b1 >= w_h) ? '0 : r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
        end
    end

    // the window after this item's shift is the one the result uses
    logic r_s2_v, r_s2_on, r_s2_last;
    t_grad w_g [3];
    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        logic [7:0] w_p [9];
        for (genvar t = 0; t < 9; t++) begin : g_tap
            assign w_p[t] = w_win[t][8*ch +: 8];
        end
        gem_grad u_grad (
            .i_clk (i_clk), .i_en (w_adv), .i_mode (r_mode),
            .i_p (w_p), .o_grad (w_g[ch])
        );
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v    <= r_s1_emit;
            r_s2_on   <= r_s1_use && r_s1_int;
            r_s2_last <= r_s1_last;
        end
    end

    // chain of square root cells, one root bit each
    t_sqrt_st w_st [3][9];
    logic [2:0] r_sat [8];
    logic       r_cv [8];
    logic       r_cl [8];
    for (genvar ch = 0; ch < 3; ch++) begin : g_root
        assign w_st[ch][0].rad  = w_g[ch].sq;
        assign w_st[ch][0].root = '0;
        for (genvar b = 0; b < 8; b++) begin : g_cell
            gem_sqrt_cell #(.BIT(7 - b)) u_cell (
                .i_clk (i_clk), .i_en (w_adv),
                .i_st (w_st[ch][b]), .o_st (w_st[ch][b+1])
            );
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_cv[k] <= 1'b0;
        end else if (w_adv) begin
            r_cv[0] <= r_s2_v;
            for (int k = 1; k < 8; k++) r_cv[k] <= r_cv[k-1];
        end
        if (w_adv) begin
            r_sat[0] <= {w_g[2].sat, w_g[1].sat, w_g[0].sat} & {3{r_s2_on}};
            r_cl[0]  <= r_s2_last;
            for (int k = 1; k < 8; k++) begin
                r_sat[k] <= r_sat[k-1];
                r_cl[k]  <= r_cl[k-1];
            end
        end
    end
    // gate off border results at the output register, by the flag set at stage two
    logic r_on [8];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_on[0] <= r_s2_on;
            for (int k = 1; k < 8; k++) r_on[k] <= r_on[k-1];
        end
    end

    function automatic logic [7:0] f_res(input logic on, input logic sat,
                                         input logic [7:0] root);
        f_res = !on ? 8'd0 : (sat ? EDGE_MAX : root);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= r_cv[7];
        end
        if (w_adv) begin
            r_odata.red_edge   <= f_res(r_on[7], r_sat[7][0], w_st[0][8].root);
            r_odata.green_edge <= f_res(r_on[7], r_sat[7][1], w_st[1][8].root);
            r_odata.blue_edge  <= f_res(r_on[7], r_sat[7][2], w_st[2][8].root);
            r_odata.alpha_out  <= ALPHA_VAL;
            r_odata.frame_last <= r_cl[7];
        end
    end
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait <= NW'(w_w + 1'b1) || $past(i_cfg_we))
        else $error("waiting count beyond lag");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_flush_no_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_data.flush |-> !w_use)
        else $error("flush treated as pixel");
endmodule
`default_nettype wire
